/* rtl/core/dtp_pkg.sv */
`default_nettype none
package dtp_pkg;

  localparam int MAX_ROWS   = 16;
  localparam int MAX_COLS   = 1024;
  localparam int FRAC_BITS  = 24;
  localparam int DATA_BITS  = 24;

  localparam int ROW_W      = $clog2(MAX_ROWS);
  localparam int HGT_W      = $clog2(MAX_ROWS + 1);
  localparam int COL_W      = $clog2(MAX_COLS);
  localparam int WID_W      = $clog2(MAX_COLS + 1);
  localparam int POS_BITS   = COL_W + FRAC_BITS;
  localparam int TBL_DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int TBL_ADDR_W = ROW_W + COL_W;

  localparam int REQ_W      = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = POS_BITS;
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 112;

  localparam logic [FRAC_BITS-1:0] STEP_RESET = FRAC_BITS'(380);

  // request kinds
  localparam logic [REQ_W-1:0] REQ_TICK  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_SEEK  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_WRITE = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_FRAC    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_ENABLE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_BEGIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_END     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERPOLATE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_WIDTH  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_HEIGHT = 3'd6;

  // input item, seek_position in the lowest bits
  typedef struct packed {
    logic signed [DATA_BITS-1:0] write_value;
    logic [COL_W-1:0]            write_col;
    logic [ROW_W-1:0]            write_row;
    logic [POS_BITS-1:0]         seek_position;
  } dtp_in_t;

  // result item, row_value in the lowest bits
  typedef struct packed {
    logic [OUT_DATA_W-POS_BITS-3*DATA_BITS-1:0] pad;
    logic [POS_BITS-1:0]                        play_position;
    logic signed [DATA_BITS-1:0]                row_max;
    logic signed [DATA_BITS-1:0]                row_min;
    logic signed [DATA_BITS-1:0]                row_value;
  } dtp_out_t;

  typedef struct packed {
    logic seek;       // load playhead from seek_position
    logic write;      // store table word, start min/max read, clear playhead
    logic tick;       // capture tick, advance playhead
    logic mm_update;  // write back row min/max
    logic loop;       // apply loop, latch position, clear row counter
    logic rd_next;    // address neighbour column, capture current word
    logic mul;        // difference times fraction
    logic sum;        // finish row value, load output register
    logic step;       // add step to fraction
  } dtp_cmd_t;

  typedef struct packed {
    logic no_rows;
    logic last_row;
    logic out_free;
  } dtp_status_t;

endpackage
`default_nettype wire

/* rtl/core/data_table_playhead_top.sv */
// Table playback engine: plays a table of up to 16 rows by 1024 columns as
// per-sample parameters, from the current column or interpolated toward the next.
// Input stream (s_axis_*): tuser selects tick, seek or table write.
//   A seek is taken in ST_IDLE alone, a write passes on through ST_WR_UPD and a tick
//   runs ST_LOOP, the row loop and ST_STEP; the row loop runs one table read pair,
//   one multiply and one sum per row through a single-port-read table memory.
// Output stream (m_axis_*): one transfer per row in use on each tick,
//   tlast on the final row. The first result is loaded into the output
//   register in ST_SUM, after ST_LOOP, ST_RD0, ST_RD1 and ST_MUL.
// The output register decouples the sides; while the receiver holds
//   m_axis_tready low the row loop waits with its result and s_axis_tready
//   stays low until the tick is finished.
// Configuration writes (cfg_wr_en, cfg_index, cfg_data) take effect at once
//   and belong only to idle periods.
// Reset (rst, synchronous) clears the playhead and configuration (step 380,
//   all else zero). Table words and row min/max are undefined until written.
`default_nettype none
module data_table_playhead_top
  import dtp_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // seek_position[33:0], write_row[37:34], write_col[47:38], write_value[71:48]
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // req_type[1:0]
  input  wire logic [REQ_W-1:0]      s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // row_value[23:0], row_min[47:24], row_max[71:48], play_position[105:72], zeros
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,
  // row_index[3:0]
  output logic [ROW_W-1:0]           m_axis_tuser,
  output logic                       m_axis_tlast
);

  dtp_cmd_t    cmd;
  dtp_status_t status;
  dtp_in_t     in_data;
  dtp_out_t    out_data;

  assign in_data      = dtp_in_t'(s_axis_tdata);
  assign m_axis_tdata = OUT_DATA_W'(out_data);

  dtp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .req      (s_axis_tuser),
    .status   (status),
    .in_ready (s_axis_tready),
    .cmd      (cmd)
  );

  dtp_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .out_ready (m_axis_tready),
    .status    (status),
    .out_valid (m_axis_tvalid),
    .out_data  (out_data),
    .out_row   (m_axis_tuser),
    .out_last  (m_axis_tlast)
  );

endmodule
`default_nettype wire

/* rtl/core/dtp_ram.sv */
`default_nettype none
module dtp_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* rtl/core/dtp_ctrl.sv */
`default_nettype none
module dtp_ctrl
  import dtp_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic [REQ_W-1:0]   req,
  input  wire dtp_status_t        status,
  output logic                    in_ready,
  output dtp_cmd_t                cmd
);

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_LOOP   = 8'b0000_0010,
    ST_RD0    = 8'b0000_0100,
    ST_RD1    = 8'b0000_1000,
    ST_MUL    = 8'b0001_0000,
    ST_SUM    = 8'b0010_0000,
    ST_STEP   = 8'b0100_0000,
    ST_WR_UPD = 8'b1000_0000
  } state_t;

  state_t state, state_next;
  logic   accept;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_ready && in_valid;

  always_comb begin
    cmd           = '0;
    cmd.seek      = accept && (req == REQ_SEEK);
    cmd.write     = accept && (req == REQ_WRITE);
    cmd.tick      = accept && (req == REQ_TICK);
    cmd.mm_update = (state == ST_WR_UPD);
    cmd.loop      = (state == ST_LOOP);
    cmd.rd_next   = (state == ST_RD1);
    cmd.mul       = (state == ST_MUL);
    cmd.sum       = (state == ST_SUM) && status.out_free;
    cmd.step      = (state == ST_STEP);
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && req == REQ_TICK) begin
          state_next = ST_LOOP;
        end else if (accept && req == REQ_WRITE) begin
          state_next = ST_WR_UPD;
        end
      end
      ST_LOOP: begin
        state_next = status.no_rows ? ST_STEP : ST_RD0;
      end
      ST_RD0:    state_next = ST_RD1;
      ST_RD1:    state_next = ST_MUL;
      ST_MUL:    state_next = ST_SUM;
      ST_SUM: begin
        if (status.out_free) begin
          state_next = status.last_row ? ST_STEP : ST_RD0;
        end
      end
      ST_STEP:   state_next = ST_IDLE;
      ST_WR_UPD: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/dtp_datapath.sv */
`default_nettype none
module dtp_datapath
  import dtp_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire dtp_in_t               in_data,
  input  wire dtp_cmd_t              cmd,
  input  wire logic                  out_ready,
  output dtp_status_t                status,
  output logic                       out_valid,
  output dtp_out_t                   out_data,
  output logic [ROW_W-1:0]           out_row,
  output logic                       out_last
);

  // configuration
  logic [FRAC_BITS-1:0] step_frac;
  logic                 loop_enable;
  logic [POS_BITS-1:0]  loop_begin;
  logic [POS_BITS-1:0]  loop_end;
  logic                 interpolate;
  logic [WID_W-1:0]     table_width;
  logic [HGT_W-1:0]     table_height;

  // playhead
  logic [COL_W-1:0]     col_idx;
  logic [FRAC_BITS:0]   col_frac;
  logic [ROW_W-1:0]     row_cnt;
  logic [POS_BITS-1:0]  pos_q;

  // write item held for the min/max update
  logic [ROW_W-1:0]            wr_row_q;
  logic                        wr_col_zero_q;
  logic signed [DATA_BITS-1:0] wr_value_q;

  // per-row work registers
  logic signed [DATA_BITS-1:0]     v_q;
  logic [2*DATA_BITS-1:0]          mm_q;
  logic signed [2*DATA_BITS+1:0]   prod_q;

  logic [WID_W-1:0]     w_sat;
  logic [HGT_W-1:0]     h_sat;
  logic [WID_W-1:0]     adv_inc;
  logic [WID_W-1:0]     nxt_inc;
  logic [COL_W-1:0]     nxt_col;
  logic [POS_BITS-1:0]  cur_pos;
  logic                 loop_jump;

  logic [TBL_ADDR_W-1:0] tbl_raddr;
  logic [DATA_BITS-1:0]  tbl_rdata;
  logic [ROW_W-1:0]      mm_raddr;
  logic [2*DATA_BITS-1:0] mm_rdata;
  logic [2*DATA_BITS-1:0] mm_wdata;

  logic signed [DATA_BITS:0]   diff;
  logic signed [FRAC_BITS:0]   frac_s;
  logic signed [DATA_BITS-1:0] mm_min;
  logic signed [DATA_BITS-1:0] mm_max;
  logic signed [DATA_BITS-1:0] row_val;

  assign w_sat = (table_width > WID_W'(MAX_COLS)) ? WID_W'(MAX_COLS) : table_width;
  assign h_sat = (table_height > HGT_W'(MAX_ROWS)) ? HGT_W'(MAX_ROWS) : table_height;

  assign adv_inc = {1'b0, col_idx} + WID_W'(1);
  assign nxt_inc = {1'b0, col_idx} + WID_W'(1);
  // neighbour of the last column, or of any column past the width, is column 0
  assign nxt_col = (nxt_inc >= w_sat) ? '0 : nxt_inc[COL_W-1:0];

  assign cur_pos   = {col_idx, col_frac[FRAC_BITS-1:0]};
  assign loop_jump = loop_enable && (loop_begin != loop_end) &&
                     ((cur_pos > loop_end) || (cur_pos < loop_begin));

  assign status.no_rows  = (h_sat == '0);
  assign status.last_row = ({1'b0, row_cnt} == h_sat - HGT_W'(1));
  assign status.out_free = !out_valid || out_ready;

  assign tbl_raddr = cmd.rd_next ? {row_cnt, nxt_col} : {row_cnt, col_idx};
  assign mm_raddr  = cmd.write ? in_data.write_row : row_cnt;

  // stored as {max, min}
  assign mm_min = mm_rdata[DATA_BITS-1:0];
  assign mm_max = mm_rdata[2*DATA_BITS-1:DATA_BITS];

  always_comb begin
    mm_wdata = mm_rdata;
    if (wr_col_zero_q) begin
      mm_wdata = {wr_value_q, wr_value_q};
    end else if (wr_value_q < mm_min) begin
      mm_wdata[DATA_BITS-1:0] = wr_value_q;
    end else if (wr_value_q > mm_max) begin
      mm_wdata[2*DATA_BITS-1:DATA_BITS] = wr_value_q;
    end
  end

  assign diff   = $signed({tbl_rdata[DATA_BITS-1], tbl_rdata}) - $signed({v_q[DATA_BITS-1], v_q});
  assign frac_s = $signed({1'b0, col_frac[FRAC_BITS-1:0]});

  // arithmetic shift of the product gives the floored quotient
  assign row_val = interpolate ? v_q + prod_q[FRAC_BITS+DATA_BITS-1:FRAC_BITS] : v_q;

  dtp_ram #(
    .WIDTH (DATA_BITS),
    .DEPTH (TBL_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (cmd.write),
    .waddr ({in_data.write_row, in_data.write_col}),
    .wdata (in_data.write_value),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  dtp_ram #(
    .WIDTH (2 * DATA_BITS),
    .DEPTH (MAX_ROWS)
  ) u_minmax (
    .clk   (clk),
    .we    (cmd.mm_update),
    .waddr (wr_row_q),
    .wdata (mm_wdata),
    .raddr (mm_raddr),
    .rdata (mm_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      step_frac    <= STEP_RESET;
      loop_enable  <= 1'b0;
      loop_begin   <= '0;
      loop_end     <= '0;
      interpolate  <= 1'b0;
      table_width  <= '0;
      table_height <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_STEP_FRAC:    step_frac    <= cfg_data[FRAC_BITS-1:0];
        CFG_LOOP_ENABLE:  loop_enable  <= cfg_data[0];
        CFG_LOOP_BEGIN:   loop_begin   <= cfg_data[POS_BITS-1:0];
        CFG_LOOP_END:     loop_end     <= cfg_data[POS_BITS-1:0];
        CFG_INTERPOLATE:  interpolate  <= cfg_data[0];
        CFG_TABLE_WIDTH:  table_width  <= cfg_data[WID_W-1:0];
        CFG_TABLE_HEIGHT: table_height <= cfg_data[HGT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_idx  <= '0;
      col_frac <= '0;
      row_cnt  <= '0;
    end else begin
      if (cmd.seek) begin
        col_idx  <= in_data.seek_position[POS_BITS-1:FRAC_BITS];
        col_frac <= {1'b0, in_data.seek_position[FRAC_BITS-1:0]};
      end else if (cmd.write) begin
        col_idx  <= '0;
        col_frac <= '0;
      end else if (cmd.tick) begin
        if (col_frac[FRAC_BITS]) begin
          col_frac[FRAC_BITS] <= 1'b0;
          col_idx <= (adv_inc >= w_sat) ? '0 : adv_inc[COL_W-1:0];
        end
      end else if (cmd.loop) begin
        if (loop_jump) begin
          col_idx  <= loop_begin[POS_BITS-1:FRAC_BITS];
          col_frac <= {1'b0, loop_begin[FRAC_BITS-1:0]};
        end
      end else if (cmd.step) begin
        col_frac <= col_frac + {1'b0, step_frac};
      end
      if (cmd.loop) begin
        row_cnt <= '0;
      end else if (cmd.sum) begin
        row_cnt <= row_cnt + ROW_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write) begin
      wr_row_q      <= in_data.write_row;
      wr_col_zero_q <= (in_data.write_col == '0);
      wr_value_q    <= in_data.write_value;
    end
    if (cmd.loop) begin
      pos_q <= loop_jump ? loop_begin : cur_pos;
    end
    if (cmd.rd_next) begin
      v_q  <= tbl_rdata;
      mm_q <= mm_rdata;
    end
    if (cmd.mul) begin
      prod_q <= diff * frac_s;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.sum) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sum) begin
      out_data.pad           <= '0;
      out_data.play_position <= pos_q;
      out_data.row_max       <= mm_q[2*DATA_BITS-1:DATA_BITS];
      out_data.row_min       <= mm_q[DATA_BITS-1:0];
      out_data.row_value     <= row_val;
      out_row                <= row_cnt;
      out_last               <= status.last_row;
    end
  end

endmodule
`default_nettype wire

/* tb/data_table_playhead_top_tb.sv */
module data_table_playhead_top_tb
  import dtp_pkg::*;
();

  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 16;
  localparam int TAIL_CYCLES   = 64;
  localparam int QUIET_LIMIT   = 2000;
  localparam int PHASE_ITEMS   = 30;

  typedef struct packed {
    logic [REQ_W-1:0] kind;
    dtp_in_t          payload;
    logic [4:0]       n_rows;
  } playhead_req_t;

  typedef struct packed {
    logic [ROW_W-1:0] idx;
    dtp_out_t         data;
    logic             last;
  } playhead_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [REQ_W-1:0]      s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [ROW_W-1:0]      m_axis_tuser;
  logic                  m_axis_tlast;

  data_table_playhead_top dut (.*);

  always #1 clk = ~clk;

  // requests waiting for the driver, rows predicted for them, rows now due
  playhead_req_t pending_reqs[$];
  playhead_row_t staged_rows[$];
  playhead_row_t expected_rows[$];

  int unsigned send_idle_pct = 17;
  int unsigned recv_idle_pct = 52;
  int unsigned mismatches = 0;
  int unsigned rows_checked = 0;
  int unsigned n_ticks = 0, n_seeks = 0, n_writes = 0, n_ignored = 0;
  int unsigned quiet_cycles = 0;

  // shadow of the block: table, row extremes, playhead, registers
  logic signed [DATA_BITS-1:0] tbl_word [TBL_DEPTH];
  bit                          tbl_set  [TBL_DEPTH];
  logic signed [DATA_BITS-1:0] row_lo [MAX_ROWS];
  logic signed [DATA_BITS-1:0] row_hi [MAX_ROWS];
  bit                          row_set [MAX_ROWS];
  logic [COL_W-1:0]            ph_col = '0;
  logic [FRAC_BITS:0]          ph_frac = '0;
  logic [FRAC_BITS-1:0]        cf_step = STEP_RESET;
  logic                        cf_loop_en = 1'b0;
  logic [POS_BITS-1:0]         cf_loop_beg = '0;
  logic [POS_BITS-1:0]         cf_loop_end = '0;
  logic                        cf_interp = 1'b0;
  logic [WID_W-1:0]            cf_width = '0;
  logic [HGT_W-1:0]            cf_height = '0;

  function automatic int word_addr(int row, int col);
    return row * MAX_COLS + col;
  endfunction

  function automatic int unsigned cols_in_use();
    return (cf_width > MAX_COLS) ? MAX_COLS : cf_width;
  endfunction

  function automatic int unsigned rows_in_use();
    return (cf_height > MAX_ROWS) ? MAX_ROWS : cf_height;
  endfunction

  function automatic logic [COL_W-1:0] next_col(logic [COL_W-1:0] col);
    int unsigned nc;
    nc = col + 1;
    if (nc >= cols_in_use()) nc = 0;
    return COL_W'(nc);
  endfunction

  // playhead as the coming tick sees it: carry a full column, then loop
  function automatic void next_head(output logic [COL_W-1:0] col,
                                    output logic [FRAC_BITS-1:0] frac);
    int unsigned c;
    logic [POS_BITS-1:0] here;
    c = ph_col;
    frac = ph_frac[FRAC_BITS-1:0];
    if (ph_frac[FRAC_BITS]) begin
      c = c + 1;
      if (c >= cols_in_use()) c = 0;
    end
    col = COL_W'(c);
    here = {col, frac};
    if (cf_loop_en && cf_loop_beg != cf_loop_end &&
        (here > cf_loop_end || here < cf_loop_beg)) begin
      col = cf_loop_beg[POS_BITS-1:FRAC_BITS];
      frac = cf_loop_beg[FRAC_BITS-1:0];
    end
  endfunction

  // true when the coming tick only touches table words and extremes already stored
  function automatic bit tick_reads_written();
    logic [COL_W-1:0]     col;
    logic [COL_W-1:0]     nc;
    logic [FRAC_BITS-1:0] frac;
    next_head(col, frac);
    nc = next_col(col);
    for (int r = 0; r < rows_in_use(); r++) begin
      if (!row_set[r] || !tbl_set[word_addr(r, col)] ||
          (cf_interp && !tbl_set[word_addr(r, nc)]))
        return 1'b0;
    end
    return 1'b1;
  endfunction

  // row values of one tick, staged in order; returns the row count
  function automatic int unsigned play_tick();
    logic [COL_W-1:0]            col;
    logic [COL_W-1:0]            nc;
    logic [FRAC_BITS-1:0]        frac;
    logic signed [DATA_BITS-1:0] v;
    longint                      diff;
    longint                      lv;
    playhead_row_t               row;
    int unsigned                 h;
    next_head(col, frac);
    nc = next_col(col);
    h = rows_in_use();
    ph_col = col;
    for (int r = 0; r < h; r++) begin
      v = tbl_word[word_addr(r, col)];
      if (cf_interp) begin
        diff = longint'(tbl_word[word_addr(r, nc)]) - longint'(v);
        lv = longint'(v) + ((diff * longint'(frac)) >>> FRAC_BITS);
        v = lv[DATA_BITS-1:0];
      end
      row.idx = ROW_W'(r);
      row.data.pad = '0;
      row.data.play_position = {col, frac};
      row.data.row_max = row_hi[r];
      row.data.row_min = row_lo[r];
      row.data.row_value = v;
      row.last = (r == h - 1);
      staged_rows.insert(staged_rows.size(), row);
    end
    ph_frac = {1'b0, frac} + cf_step;
    return h;
  endfunction

  function automatic dtp_in_t random_payload();
    logic [95:0] bits;
    bits = {$urandom, $urandom, $urandom};
    return bits[IN_DATA_W-1:0];
  endfunction

  function automatic logic [POS_BITS-1:0] pos_in(int unsigned col);
    return {COL_W'(col), FRAC_BITS'($urandom)};
  endfunction

  function automatic void enqueue(logic [REQ_W-1:0] kind, dtp_in_t payload,
                                  int unsigned n_rows);
    playhead_req_t req;
    req.kind = kind;
    req.payload = payload;
    req.n_rows = 5'(n_rows);
    pending_reqs.insert(pending_reqs.size(), req);
    case (kind)
      REQ_TICK:  n_ticks++;
      REQ_SEEK:  n_seeks++;
      REQ_WRITE: n_writes++;
      default:   n_ignored++;
    endcase
  endfunction

  function automatic void push_seek(logic [POS_BITS-1:0] pos);
    dtp_in_t p;
    p = random_payload();
    p.seek_position = pos;
    ph_col = pos[POS_BITS-1:FRAC_BITS];
    ph_frac = {1'b0, pos[FRAC_BITS-1:0]};
    enqueue(REQ_SEEK, p, 0);
  endfunction

  // a row's first word goes to column 0 so its extremes are defined
  function automatic void push_write(int unsigned row, int unsigned col,
                                     logic signed [DATA_BITS-1:0] val);
    dtp_in_t p;
    int      a;
    if (!row_set[row]) col = 0;
    a = word_addr(row, col);
    tbl_word[a] = val;
    tbl_set[a] = 1'b1;
    if (col == 0) begin
      row_lo[row] = val;
      row_hi[row] = val;
      row_set[row] = 1'b1;
    end else if (val < row_lo[row]) begin
      row_lo[row] = val;
    end else if (val > row_hi[row]) begin
      row_hi[row] = val;
    end
    ph_col = '0;
    ph_frac = '0;
    p = random_payload();
    p.write_row = ROW_W'(row);
    p.write_col = COL_W'(col);
    p.write_value = val;
    enqueue(REQ_WRITE, p, 0);
  endfunction

  // playhead headed for unwritten columns is sent home first
  function automatic void push_tick();
    if (!tick_reads_written()) push_seek('0);
    if (tick_reads_written()) enqueue(REQ_TICK, random_payload(), play_tick());
  endfunction

  function automatic void push_ignored();
    enqueue(REQ_UNUSED, random_payload(), 0);
  endfunction

  task automatic drain();
    while (pending_reqs.size() != 0 || staged_rows.size() != 0 ||
           expected_rows.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      CFG_STEP_FRAC:    cf_step = val[FRAC_BITS-1:0];
      CFG_LOOP_ENABLE:  cf_loop_en = val[0];
      CFG_LOOP_BEGIN:   cf_loop_beg = val[POS_BITS-1:0];
      CFG_LOOP_END:     cf_loop_end = val[POS_BITS-1:0];
      CFG_INTERPOLATE:  cf_interp = val[0];
      CFG_TABLE_WIDTH:  cf_width = val[WID_W-1:0];
      CFG_TABLE_HEIGHT: cf_height = val[HGT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_regs(logic [FRAC_BITS-1:0] step, logic loop_en,
                            logic [POS_BITS-1:0] beg, logic [POS_BITS-1:0] fin,
                            logic interp, logic [WID_W-1:0] width,
                            logic [HGT_W-1:0] height);
    drain();
    set_reg(CFG_STEP_FRAC, CFG_DATA_W'(step));
    set_reg(CFG_LOOP_ENABLE, CFG_DATA_W'(loop_en));
    set_reg(CFG_LOOP_BEGIN, beg);
    set_reg(CFG_LOOP_END, fin);
    set_reg(CFG_INTERPOLATE, CFG_DATA_W'(interp));
    set_reg(CFG_TABLE_WIDTH, CFG_DATA_W'(width));
    set_reg(CFG_TABLE_HEIGHT, CFG_DATA_W'(height));
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  // one register setting: fill the rows in use, then mostly ticks
  task automatic run_phase(logic [FRAC_BITS-1:0] step, logic loop_en,
                           logic [POS_BITS-1:0] beg, logic [POS_BITS-1:0] fin,
                           logic interp, logic [WID_W-1:0] width,
                           logic [HGT_W-1:0] height, int unsigned fill_cols,
                           bit fill_top, int unsigned n_items);
    int unsigned pick;
    int unsigned col;
    apply_regs(step, loop_en, beg, fin, interp, width, height);
    for (int r = 0; r < rows_in_use(); r++) begin
      for (int c = 0; c < fill_cols; c++) push_write(r, c, DATA_BITS'($urandom));
      if (fill_top) begin
        push_write(r, MAX_COLS - 2, DATA_BITS'($urandom));
        push_write(r, MAX_COLS - 1, DATA_BITS'($urandom));
      end
    end
    for (int i = 0; i < n_items; i++) begin
      if (i == n_items / 2) drain();
      pick = $urandom_range(99);
      if (pick < 64) begin
        push_tick();
      end else if (pick < 76) begin
        col = $urandom_range(fill_cols - 1);
        if (fill_top && $urandom_range(1)) col = MAX_COLS - 1 - $urandom_range(1);
        if ($urandom_range(3) == 0) push_seek(POS_BITS'({$urandom, $urandom}));
        else push_seek(pos_in(col));
      end else if (pick < 88) begin
        if ($urandom_range(1)) col = $urandom_range(fill_cols - 1);
        else col = $urandom_range(MAX_COLS - 1);
        push_write($urandom_range(MAX_ROWS - 1), col, DATA_BITS'($urandom));
      end else begin
        push_ignored();
      end
    end
  endtask

  task automatic release_rows();
    playhead_req_t req;
    playhead_row_t row;
    req = pending_reqs.pop_front();
    repeat (req.n_rows) begin
      row = staged_rows.pop_front();
      expected_rows.insert(expected_rows.size(), row);
    end
  endtask

  task automatic check_row();
    playhead_row_t want;
    dtp_out_t      got;
    got = m_axis_tdata;
    rows_checked++;
    if (expected_rows.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("row %0d result with nothing expected", m_axis_tuser);
      return;
    end
    want = expected_rows.pop_front();
    if (got !== want.data || m_axis_tuser !== want.idx || m_axis_tlast !== want.last) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("want row %0d value %0d min %0d max %0d pos %h last %b",
                 want.idx, want.data.row_value, want.data.row_min,
                 want.data.row_max, want.data.play_position, want.last);
        $display(" got row %0d value %0d min %0d max %0d pos %h last %b pad %h",
                 m_axis_tuser, got.row_value, got.row_min, got.row_max,
                 got.play_position, m_axis_tlast, got.pad);
      end
    end
  endtask

  always @(posedge clk) begin : req_driver
    logic offer;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      offer = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        release_rows();
        offer = 1'b0;
      end
      if (!offer && pending_reqs.size() != 0 &&
          $urandom_range(99) >= send_idle_pct) begin
        s_axis_tuser <= pending_reqs[0].kind;
        s_axis_tdata <= pending_reqs[0].payload;
        offer = 1'b1;
      end
      s_axis_tvalid <= offer;
    end
  end

  always @(posedge clk) begin : row_monitor
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_row();
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("no transfer for %0d cycles, %0d rows still due",
               QUIET_LIMIT, expected_rows.size() + staged_rows.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned w;
    int unsigned h;
    logic [POS_BITS-1:0] beg;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset state: no rows in use, so a tick yields nothing but moves the playhead
    push_tick();
    push_ignored();

    // three-column table; extremes of the data word and of the running min/max
    apply_regs('1, 1'b0, '0, '0, 1'b0, WID_W'(3), HGT_W'(2));
    push_write(0, 0, 24'sh7FFFFF);
    push_write(0, 1, -24'sh800000);
    push_write(0, 2, 24'sd5);
    push_write(1, 0, -24'sh800000);
    push_write(1, 1, 24'sh7FFFFF);
    push_write(1, 2, '0);
    push_write(0, MAX_COLS - 1, -24'sd1);
    push_write(1, MAX_COLS - 1, 24'sh555555);
    push_write(MAX_ROWS - 1, 0, 24'sh2AAAAA);
    repeat (4) push_tick();
    // last column of storage, then wrap back to column 0
    push_seek('1);
    repeat (2) push_tick();
    push_ignored();

    // loop from 1.5 to 2.0 with interpolation; column 2 interpolates toward 0
    apply_regs(24'h400000, 1'b1, {10'd1, 24'h800000}, {10'd2, 24'h0}, 1'b1,
               WID_W'(3), HGT_W'(2));
    push_seek('0);
    repeat (4) push_tick();

    run_phase(FRAC_BITS'($urandom_range(24'h400000, 24'hFFFFFF)), 1'b0, '0, '0, 1'b0,
              WID_W'(6), HGT_W'(4), 6, 1'b0, PHASE_ITEMS);
    beg = pos_in($urandom_range(3));
    run_phase(FRAC_BITS'($urandom_range(24'h400000, 24'hFFFFFF)), 1'b1, beg,
              beg + {COL_W'($urandom_range(3)), FRAC_BITS'($urandom)}, 1'b1,
              11'h7FF, 5'h1F, 4, 1'b1, PHASE_ITEMS);

    send_idle_pct = 52;
    recv_idle_pct = 17;
    run_phase('1, 1'b0, '0, '0, 1'b1, '0, HGT_W'(3), 1, 1'b0, PHASE_ITEMS);
    run_phase(FRAC_BITS'($urandom_range(24'h400000, 24'hFFFFFF)), 1'b1, '1, '0, 1'b1,
              WID_W'(MAX_COLS), HGT_W'(MAX_ROWS), 4, 1'b1, PHASE_ITEMS);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    w = $urandom_range(2, 8);
    h = $urandom_range(1, MAX_ROWS);
    beg = pos_in($urandom_range(w - 1));
    run_phase('0, 1'b1, beg, beg, 1'($urandom_range(1)), WID_W'(w), HGT_W'(h), w,
              1'b0, PHASE_ITEMS);
    w = $urandom_range(2, 8);
    h = $urandom_range(1, MAX_ROWS);
    run_phase(FRAC_BITS'($urandom), 1'($urandom_range(1)), pos_in($urandom_range(w - 1)),
              pos_in($urandom_range(w - 1)), 1'($urandom_range(1)), WID_W'(w),
              HGT_W'(h), w, 1'b0, PHASE_ITEMS);

    drain();
    repeat (TAIL_CYCLES) @(negedge clk);
    mismatches += expected_rows.size();

    $display("covered %0d ticks, %0d seeks, %0d table writes, %0d ignored requests",
             n_ticks, n_seeks, n_writes, n_ignored);
    $display("%0d row results checked over eight register settings, %0d mismatches",
             rows_checked, mismatches);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* data_table_playhead_top.f */
rtl/core/dtp_pkg.sv
rtl/core/dtp_ram.sv
rtl/core/dtp_ctrl.sv
rtl/core/dtp_datapath.sv
rtl/core/data_table_playhead_top.sv
tb/data_table_playhead_top_tb.sv
